[hw/rtl/dtmi_pkg.sv]
// shared types and constants of the difference triangle mark inserter
`timescale 1ns / 1ps

package dtmi_pkg;

	// fixed field widths of the command and result transactions
	localparam int KIND_W  = 3;
	localparam int MARK_W  = 8;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 3;

	// value of the mark limit register after reset
	localparam logic [MARK_W-1:0] MARK_LIMIT_RESET = 8'd255;

	// command codes
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 3'd0,
		KIND_BEGIN  = 3'd1,
		KIND_TRY    = 3'd2,
		KIND_COMMIT = 3'd3,
		KIND_TOGGLE = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_COLLISION = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_RANGE     = 2'd3
	} status_t;

endpackage

[hw/rtl/difference_triangle_mark_inserter.sv]
// top level of the difference triangle mark inserter: command stage, check logic, result register
`timescale 1ns / 1ps

//  channel   signals                          direction  contents
//  command   cmd_valid / cmd_ready            in         kind, mark, slot
//  result    res_valid / res_ready            out        accepted, status, marks_placed,
//                                                        block_length, block_full
//  config    cfg_we / cfg_wdata               in         mark_limit
//
//  One command per cycle unless the result stalls. The slot memory is read when a command
//  is taken and its read data is registered alongside it in stage 1; the check and all
//  block state updates happen as stage 1 moves into the result register, which presents
//  the result. Reset clears the valid flags, resets the block state and sets mark_limit to
//  255; the slot memory is left as is and masked by per-slot written flags. A stalled
//  result holds stage 1, and cmd_ready drops only while stage 1 is full and cannot move.

module difference_triangle_mark_inserter #(
	parameter int BLOCKS          = 16,
	parameter int MARKS_PER_BLOCK = 4,
	parameter int RULER_BITS      = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [dtmi_pkg::MARK_W-1:0]   cfg_wdata,
	// command channel
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [dtmi_pkg::KIND_W-1:0]   kind,
	input  logic [dtmi_pkg::MARK_W-1:0]   mark,
	input  logic [dtmi_pkg::SLOT_W-1:0]   slot,
	// result channel
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          accepted,
	output logic [1:0]                    status,
	output logic [dtmi_pkg::COUNT_W-1:0]  marks_placed,
	output logic [dtmi_pkg::MARK_W-1:0]   block_length,
	output logic                          block_full
);

	localparam int RB      = RULER_BITS;
	localparam int SLOT_AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam logic [dtmi_pkg::MARK_W:0] RB_LIMIT  = (dtmi_pkg::MARK_W + 1)'(RULER_BITS);
	localparam logic [6:0]                BLK_LIMIT = 7'(BLOCKS);
	localparam logic [dtmi_pkg::COUNT_W-1:0] MPB    = dtmi_pkg::COUNT_W'(MARKS_PER_BLOCK);
	localparam logic [RB-1:0]             BIT0      = RB'(1);

	// block state
	logic [RB-1:0]                   rev_q, nat_q, blk_q, com_q;
	logic [dtmi_pkg::MARK_W-1:0]     largest_q;
	logic [dtmi_pkg::COUNT_W-1:0]    placed_q;
	logic [dtmi_pkg::MARK_W-1:0]     mark_limit_q;
	logic [BLOCKS-1:0]               slot_vld_q;
	logic [RB-1:0]                   slot_mem [BLOCKS];

	// stage 1
	logic                            valid_s1;
	dtmi_pkg::kind_t                 kind_s1;
	logic [dtmi_pkg::MARK_W-1:0]     mark_s1;
	logic [dtmi_pkg::SLOT_W-1:0]     slot_s1;
	logic [RB-1:0]                   slot_rd_s1;
	logic                            fwd_s1;

	// result register
	logic                            res_valid_q;
	logic                            accepted_q;
	dtmi_pkg::status_t               status_q;
	logic [dtmi_pkg::COUNT_W-1:0]    placed_out_q;
	logic [dtmi_pkg::MARK_W-1:0]     largest_out_q;
	logic                            full_out_q;

	// handshake
	logic cmd_acc, adv_s1;
	assign adv_s1    = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign cmd_acc   = cmd_valid && cmd_ready;

	// slot indexes
	logic [SLOT_AW-1:0] idx_in, idx_s1;
	logic               slot_ok_s1;
	assign idx_in     = SLOT_AW'(slot);
	assign idx_s1     = SLOT_AW'(slot_s1);
	assign slot_ok_s1 = 7'(slot_s1) < BLK_LIMIT;

	// try mark check
	logic                        ext, full_now, range_bad, hit;
	logic [dtmi_pkg::MARK_W-1:0] gap_up, gap_dn;
	logic [RB-1:0]               left, right, both;
	assign ext       = mark_s1 > largest_q;
	assign gap_up    = mark_s1 - largest_q;
	assign gap_dn    = largest_q - mark_s1;
	assign full_now  = placed_q >= MPB;
	assign range_bad = (mark_s1 == '0) || (mark_s1 > mark_limit_q) ||
		({1'b0, mark_s1} >= RB_LIMIT);
	assign left      = ext ? (rev_q << gap_up) : (rev_q >> gap_dn);
	assign right     = ext ? '0 : (nat_q >> mark_s1);
	assign both      = left | right;
	assign hit       = (|(left & right)) || (|(both & (com_q | blk_q)));

	// spectrum of the slot being toggled
	logic [RB-1:0] tog_data;
	assign tog_data = (fwd_s1 ? blk_q : slot_rd_s1) & {RB{slot_vld_q[idx_s1]}};

	// next state and result of the command in stage 1
	logic [RB-1:0]                rev_d, nat_d, blk_d, com_d;
	logic [dtmi_pkg::MARK_W-1:0]  largest_d;
	logic [dtmi_pkg::COUNT_W-1:0] placed_d;
	logic [BLOCKS-1:0]            slot_vld_d;
	logic                         slot_we;
	logic                         acc_d;
	dtmi_pkg::status_t            status_d;

	always_comb begin
		rev_d      = rev_q;
		nat_d      = nat_q;
		blk_d      = blk_q;
		com_d      = com_q;
		largest_d  = largest_q;
		placed_d   = placed_q;
		slot_vld_d = slot_vld_q;
		slot_we    = 1'b0;
		acc_d      = 1'b0;
		status_d   = dtmi_pkg::STATUS_OK;
		unique case (kind_s1)
			dtmi_pkg::KIND_CLEAR: begin
				rev_d      = BIT0;
				nat_d      = BIT0;
				blk_d      = '0;
				com_d      = '0;
				largest_d  = '0;
				placed_d   = '0;
				slot_vld_d = '0;
				acc_d      = 1'b1;
			end
			dtmi_pkg::KIND_BEGIN: begin
				rev_d     = BIT0;
				nat_d     = BIT0;
				blk_d     = '0;
				largest_d = '0;
				placed_d  = '0;
				acc_d     = 1'b1;
			end
			dtmi_pkg::KIND_TRY: begin
				priority if (full_now) begin
					status_d = dtmi_pkg::STATUS_FULL;
				end else if (range_bad) begin
					status_d = dtmi_pkg::STATUS_RANGE;
				end else if (hit) begin
					status_d = dtmi_pkg::STATUS_COLLISION;
				end else begin
					acc_d    = 1'b1;
					nat_d    = nat_q ^ (BIT0 << mark_s1);
					if (ext) begin
						rev_d     = left | BIT0;
						largest_d = mark_s1;
					end else begin
						rev_d = rev_q ^ (BIT0 << gap_dn);
					end
					blk_d    = blk_q | both;
					placed_d = placed_q + 1'b1;
				end
			end
			dtmi_pkg::KIND_COMMIT: begin
				if (slot_ok_s1) begin
					slot_we            = 1'b1;
					slot_vld_d[idx_s1] = 1'b1;
					com_d              = com_q | blk_q;
					acc_d              = 1'b1;
				end else begin
					status_d = dtmi_pkg::STATUS_RANGE;
				end
			end
			dtmi_pkg::KIND_TOGGLE: begin
				if (slot_ok_s1) begin
					com_d = com_q ^ tog_data;
					acc_d = 1'b1;
				end else begin
					status_d = dtmi_pkg::STATUS_RANGE;
				end
			end
			default: begin
				acc_d = 1'b0;
			end
		endcase
	end

	// slot memory: write on commit, registered read when a command is taken
	always_ff @(posedge clk) begin
		if (adv_s1 && slot_we) begin
			slot_mem[idx_s1] <= blk_q;
		end
		if (cmd_acc) begin
			slot_rd_s1 <= slot_mem[idx_in];
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			kind_s1 <= dtmi_pkg::kind_t'(kind);
			mark_s1 <= mark;
			slot_s1 <= slot;
			// a commit to the same slot finishing now is not yet visible in the read
			fwd_s1  <= adv_s1 && slot_we && (idx_s1 == idx_in);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			accepted_q    <= acc_d;
			status_q      <= status_d;
			placed_out_q  <= placed_d;
			largest_out_q <= largest_d;
			full_out_q    <= placed_d >= MPB;
		end
	end

	// control and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			rev_q        <= BIT0;
			nat_q        <= BIT0;
			blk_q        <= '0;
			com_q        <= '0;
			largest_q    <= '0;
			placed_q     <= '0;
			slot_vld_q   <= '0;
			mark_limit_q <= dtmi_pkg::MARK_LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				mark_limit_q <= cfg_wdata;
			end
			if (cmd_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				rev_q      <= rev_d;
				nat_q      <= nat_d;
				blk_q      <= blk_d;
				com_q      <= com_d;
				largest_q  <= largest_d;
				placed_q   <= placed_d;
				slot_vld_q <= slot_vld_d;
			end
		end
	end

	// outputs
	assign res_valid    = res_valid_q;
	assign accepted     = accepted_q;
	assign status       = status_q;
	assign marks_placed = placed_out_q;
	assign block_length = largest_out_q;
	assign block_full   = full_out_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		placed_q <= MPB)
		else $error("placed mark count beyond block size");

	a_mark0_kept: assert property (@(posedge clk) disable iff (!arst_n)
		nat_q[0] && rev_q[0])
		else $error("mark 0 lost from current ruler");

	a_acc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && accepted_q |-> status_q == dtmi_pkg::STATUS_OK)
		else $error("accepted transaction with error status");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> valid_s1 && res_valid_q && !res_ready)
		else $error("command stalled without a blocked result");

endmodule
